// File: src/dtp_pkg.sv
`timescale 1ns / 1ps

package dtp_pkg;

    // Parser states, one per position in the number syntax.
    typedef enum logic [3:0] {
        PS_START,
        PS_SIGNED,
        PS_INT,
        PS_DOT0,
        PS_FRAC,
        PS_EXP0,
        PS_EXP1,
        PS_EXP,
        PS_WORD,
        PS_END,
        PS_ERR,
        PS_END_INF,
        PS_END_NAN
    } t_parse_state;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPSUM,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_ctrl_state;

    // Result of the shared saturating adder.
    typedef struct packed {
        logic signed [15:0] sum;
        logic               ovf;
    } t_add_res;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SYNTAX  = 2'd1;
    localparam logic [1:0] ST_EXP_OVF = 2'd2;
    localparam logic [1:0] ST_DIGITS  = 2'd3;

    // Special kinds.
    localparam logic [1:0] KIND_NUMBER = 2'd0;
    localparam logic [1:0] KIND_INF    = 2'd1;
    localparam logic [1:0] KIND_NAN    = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_E_UC  = 8'h45;
    localparam logic [7:0] CH_E_LC  = 8'h65;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_A     = 8'h41;

    // Exponent limits.
    localparam logic signed [15:0] EXP_MAX = 16'sd32767;
    localparam logic [14:0]        ACC_MAX = 15'd32767;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'd65:8'd90], [8'd97:8'd122]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'd48:8'd57]});
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c inside {[8'd97:8'd122]}) ? (c - 8'd32) : c;
    endfunction

    // Largest accumulator value that still takes digit d without passing 32767.
    function automatic logic [14:0] acc_limit(input logic [3:0] d);
        return (d >= 4'd8) ? 15'd3275 : 15'd3276;
    endfunction

endpackage

// File: src/dtp_sat_add.sv
`timescale 1ns / 1ps

// Signed 16-bit adder that saturates to the 16-bit range and flags overflow.
// It serves the exponent offset steps and the final exponent sum.
module dtp_sat_add (
    input  logic signed [15:0] i_a,
    input  logic signed [15:0] i_b,
    output dtp_pkg::t_add_res  o_res
);

    logic signed [16:0] w_sum;

    assign w_sum = {i_a[15], i_a} + {i_b[15], i_b};

    // The two top bits differ only when the sum left the 16-bit range.
    always_comb begin
        o_res.ovf = (w_sum[16] != w_sum[15]);
        if (w_sum[16] != w_sum[15]) begin
            o_res.sum = w_sum[16] ? -16'sd32768 : dtp_pkg::EXP_MAX;
        end else begin
            o_res.sum = w_sum[15:0];
        end
    end

endmodule

// File: src/dtp_digit_ram.sv
`timescale 1ns / 1ps

// Mantissa digit store: one write port, one read port with registered data.
module dtp_digit_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [3:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [3:0]    o_rdata
);

    logic [3:0] r_mem [DEPTH];
    logic [3:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/decimal_text_parser.sv
`timescale 1ns / 1ps
// Decimal number text parser. Each character beat is taken in one cycle while idle.
// After the end marker come the exponent sum (numbers only), a read and a check per
// trailing zero stripped, and a read and an offer per result beat, held through any
// output stall; the digit store's single read port paces scan and emission.
// Reset is synchronous and active low; it clears the parser and the sequencer,
// while the digit store is left as is and needs no clearing pass.
module decimal_text_parser #(
    parameter int MAX_DIGITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_character,
    input  logic               i_finish,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_digit,
    output logic               o_last,
    output logic               o_negative,
    output logic signed [15:0] o_exponent,
    output logic [5:0]         o_digit_count,
    output logic [1:0]         o_special_kind,
    output logic [1:0]         o_status
);

    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DIGITS);

    // Parser registers.
    dtp_pkg::t_parse_state r_ps, n_ps;
    logic [CW-1:0]         r_held, n_held;
    logic [14:0]           r_acc, n_acc;
    logic signed [15:0]    r_offset, n_offset;
    logic                  r_expneg, n_expneg;
    logic                  r_sign, n_sign;
    logic [3:0][7:0]       r_word, n_word;
    logic [2:0]            r_seen, n_seen;
    logic [1:0]            r_ec, n_ec;

    // Sequencer and result registers.
    dtp_pkg::t_ctrl_state  r_state, n_state;
    logic [CW-1:0]         r_idx, n_idx;
    logic signed [15:0]    r_exp_out, n_exp_out;
    logic [1:0]            r_kind, n_kind;

    logic                  w_accept;
    logic                  w_last;
    logic                  w_dot_dec;
    logic signed [15:0]    w_add_b;
    dtp_pkg::t_add_res     w_add;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [3:0]            w_wdata;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic [3:0]            w_rdata;
    logic [CW-1:0]         w_len_m1;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_len_m1 = r_held - CW'(1);
    assign w_last   = (r_held == '0) || (r_idx == w_len_m1);

    // Shared adder operand: exponent literal in the sum step, else +1 or -1.
    assign w_dot_dec = (r_ps == dtp_pkg::PS_DOT0) && (i_character == dtp_pkg::CH_ZERO);
    always_comb begin
        if (r_state == dtp_pkg::S_EXPSUM) begin
            w_add_b = r_expneg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
        end else begin
            w_add_b = w_dot_dec ? -16'sd1 : 16'sd1;
        end
    end

    dtp_sat_add u_add (
        .i_a   (r_offset),
        .i_b   (w_add_b),
        .o_res (w_add)
    );

    dtp_digit_ram #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dtp_pkg::S_IDLE: begin
                if (w_accept && i_finish) begin
                    if (r_ps inside {dtp_pkg::PS_START, dtp_pkg::PS_SIGNED,
                                     dtp_pkg::PS_EXP0, dtp_pkg::PS_EXP1,
                                     dtp_pkg::PS_WORD, dtp_pkg::PS_ERR,
                                     dtp_pkg::PS_END_INF, dtp_pkg::PS_END_NAN}) begin
                        n_state = dtp_pkg::S_EMIT_RD;
                    end else begin
                        n_state = dtp_pkg::S_EXPSUM;
                    end
                end
            end
            dtp_pkg::S_EXPSUM: n_state = dtp_pkg::S_SCAN_RD;
            dtp_pkg::S_SCAN_RD: begin
                n_state = (r_held > CW'(1)) ? dtp_pkg::S_SCAN_CHK : dtp_pkg::S_EMIT_RD;
            end
            dtp_pkg::S_SCAN_CHK: begin
                n_state = (w_rdata == 4'd0) ? dtp_pkg::S_SCAN_RD : dtp_pkg::S_EMIT_RD;
            end
            dtp_pkg::S_EMIT_RD: n_state = dtp_pkg::S_EMIT_OUT;
            dtp_pkg::S_EMIT_OUT: begin
                if (i_out_ready) begin
                    n_state = w_last ? dtp_pkg::S_IDLE : dtp_pkg::S_EMIT_RD;
                end
            end
            default: n_state = dtp_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshakes and the read port.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        w_re        = 1'b0;
        w_raddr     = r_idx[AW-1:0];
        case (r_state)
            dtp_pkg::S_IDLE: o_in_ready = 1'b1;
            dtp_pkg::S_SCAN_RD: begin
                w_re    = (r_held > CW'(1));
                w_raddr = w_len_m1[AW-1:0];
            end
            dtp_pkg::S_EMIT_RD: w_re = (r_held != '0);
            dtp_pkg::S_EMIT_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    // Parser and result data path.
    always_comb begin
        logic [7:0]  c;
        logic [7:0]  u0;
        logic [7:0]  u1;
        logic [7:0]  u2;
        logic [7:0]  u3;
        logic        err;
        logic        push;
        logic        off_step;
        logic        ovf;
        logic        full;

        c        = i_character;
        err      = 1'b0;
        push     = 1'b0;
        off_step = 1'b0;
        ovf      = 1'b0;
        full     = 1'b0;

        n_ps      = r_ps;
        n_held    = r_held;
        n_acc     = r_acc;
        n_offset  = r_offset;
        n_expneg  = r_expneg;
        n_sign    = r_sign;
        n_word    = r_word;
        n_seen    = r_seen;
        n_ec      = r_ec;
        n_idx     = r_idx;
        n_exp_out = r_exp_out;
        n_kind    = r_kind;
        w_we      = 1'b0;
        w_waddr   = r_held[AW-1:0];
        w_wdata   = c[3:0];

        // Word buffer takes the first four characters, counted from the start.
        if (r_seen < 3'd4) begin
            n_word[r_seen[1:0]] = c;
        end
        if (r_seen < 3'd7) begin
            n_seen = r_seen + 3'd1;
        end
        u0 = dtp_pkg::upcase(n_word[0]);
        u1 = dtp_pkg::upcase(n_word[1]);
        u2 = dtp_pkg::upcase(n_word[2]);
        u3 = dtp_pkg::upcase(n_word[3]);

        if (r_state == dtp_pkg::S_IDLE && w_accept && !i_finish) begin
            // One character beat.
            case (r_ps)
                dtp_pkg::PS_START, dtp_pkg::PS_SIGNED: begin
                    if (r_ps == dtp_pkg::PS_START && c == dtp_pkg::CH_PLUS) begin
                        n_ps = dtp_pkg::PS_SIGNED;
                    end else if (r_ps == dtp_pkg::PS_START && c == dtp_pkg::CH_MINUS) begin
                        n_sign = 1'b1;
                        n_ps   = dtp_pkg::PS_SIGNED;
                    end else if (c == dtp_pkg::CH_DOT) begin
                        n_ps = dtp_pkg::PS_DOT0;
                    end else if (c == dtp_pkg::CH_ZERO) begin
                        n_ps = dtp_pkg::PS_INT;
                    end else if (dtp_pkg::is_digit(c)) begin
                        push     = 1'b1;
                        off_step = 1'b1;
                        n_ps     = dtp_pkg::PS_INT;
                    end else if (dtp_pkg::is_alpha(c)) begin
                        n_ps = dtp_pkg::PS_WORD;
                    end else if (!(r_ps == dtp_pkg::PS_START && dtp_pkg::is_space(c))) begin
                        err = 1'b1;
                    end
                end
                dtp_pkg::PS_INT: begin
                    if (c == dtp_pkg::CH_ZERO && r_held == '0) begin
                        // Leading zero is dropped.
                    end else if (dtp_pkg::is_digit(c)) begin
                        push     = 1'b1;
                        off_step = 1'b1;
                    end else if (c == dtp_pkg::CH_DOT) begin
                        n_ps = (r_held == '0) ? dtp_pkg::PS_DOT0 : dtp_pkg::PS_FRAC;
                    end else if (c == dtp_pkg::CH_E_UC || c == dtp_pkg::CH_E_LC) begin
                        n_ps = dtp_pkg::PS_EXP0;
                    end else if (dtp_pkg::is_space(c)) begin
                        n_ps = dtp_pkg::PS_END;
                    end else begin
                        err = 1'b1;
                    end
                end
                dtp_pkg::PS_DOT0, dtp_pkg::PS_FRAC: begin
                    if (r_ps == dtp_pkg::PS_DOT0 && c == dtp_pkg::CH_ZERO) begin
                        off_step = 1'b1;
                    end else if (r_ps == dtp_pkg::PS_DOT0 &&
                                 (c == dtp_pkg::CH_E_UC || c == dtp_pkg::CH_E_LC)) begin
                        if (r_offset == 16'sd0) begin
                            err = 1'b1;
                        end else begin
                            // Zero mantissa: restart the store with one zero digit.
                            w_we     = 1'b1;
                            w_waddr  = '0;
                            w_wdata  = 4'd0;
                            n_held   = CW'(1);
                            n_offset = 16'sd0;
                            n_ps     = dtp_pkg::PS_EXP0;
                        end
                    end else begin
                        n_ps = dtp_pkg::PS_FRAC;
                        if (dtp_pkg::is_digit(c)) begin
                            push = 1'b1;
                        end else if (c == dtp_pkg::CH_E_UC || c == dtp_pkg::CH_E_LC) begin
                            n_ps = dtp_pkg::PS_EXP0;
                        end else if (dtp_pkg::is_space(c)) begin
                            n_ps = dtp_pkg::PS_END;
                        end else begin
                            err = 1'b1;
                        end
                    end
                end
                dtp_pkg::PS_EXP0, dtp_pkg::PS_EXP1, dtp_pkg::PS_EXP: begin
                    if (r_ps == dtp_pkg::PS_EXP0 && c == dtp_pkg::CH_PLUS) begin
                        n_ps = dtp_pkg::PS_EXP1;
                    end else if (r_ps == dtp_pkg::PS_EXP0 && c == dtp_pkg::CH_MINUS) begin
                        n_expneg = 1'b1;
                    end else if (dtp_pkg::is_digit(c)) begin
                        // Accumulate ten times plus digit, saturating at the limit.
                        if (r_acc > dtp_pkg::acc_limit(c[3:0])) begin
                            ovf   = 1'b1;
                            n_acc = dtp_pkg::ACC_MAX;
                        end else begin
                            n_acc = {r_acc[11:0], 3'b000} + {r_acc[13:0], 1'b0}
                                    + {11'd0, c[3:0]};
                        end
                        n_ps = dtp_pkg::PS_EXP;
                    end else if (dtp_pkg::is_space(c)) begin
                        n_ps = dtp_pkg::PS_END;
                    end else begin
                        err = 1'b1;
                    end
                end
                dtp_pkg::PS_WORD: begin
                    if (n_seen > 3'd4) begin
                        err = 1'b1;
                    end else if (dtp_pkg::is_alpha(c) && n_seen >= 3'd3) begin
                        if ((n_seen == 3'd3 && u0 == dtp_pkg::CH_I && u1 == dtp_pkg::CH_N &&
                             u2 == dtp_pkg::CH_F) ||
                            (n_seen == 3'd4 && u0 == dtp_pkg::CH_PLUS &&
                             u1 == dtp_pkg::CH_I && u2 == dtp_pkg::CH_N &&
                             u3 == dtp_pkg::CH_F)) begin
                            n_ps = dtp_pkg::PS_END_INF;
                        end else if (n_seen == 3'd4 && u0 == dtp_pkg::CH_MINUS &&
                                     u1 == dtp_pkg::CH_I && u2 == dtp_pkg::CH_N &&
                                     u3 == dtp_pkg::CH_F) begin
                            n_sign = 1'b1;
                            n_ps   = dtp_pkg::PS_END_INF;
                        end else if (n_seen == 3'd3 && u0 == dtp_pkg::CH_N &&
                                     u1 == dtp_pkg::CH_A && u2 == dtp_pkg::CH_N) begin
                            n_ps = dtp_pkg::PS_END_NAN;
                        end
                    end
                end
                dtp_pkg::PS_END, dtp_pkg::PS_END_INF, dtp_pkg::PS_END_NAN: begin
                    if (!dtp_pkg::is_space(c)) begin
                        err = 1'b1;
                    end
                end
                default: ;
            endcase

            // Digit push into the store, dropped once it is full.
            if (push) begin
                if (r_held < MAX_CNT) begin
                    w_we   = 1'b1;
                    n_held = r_held + CW'(1);
                end else begin
                    full = 1'b1;
                end
            end

            // Offset step through the shared adder.
            if (off_step) begin
                if (w_add.ovf) begin
                    ovf = 1'b1;
                end else begin
                    n_offset = w_add.sum;
                end
            end

            // First flag wins; a syntax error overrides everything.
            if (err) begin
                n_ps = dtp_pkg::PS_ERR;
                n_ec = dtp_pkg::ST_SYNTAX;
            end else if (r_ec == dtp_pkg::ST_OK) begin
                if (full) begin
                    n_ec = dtp_pkg::ST_DIGITS;
                end else if (ovf) begin
                    n_ec = dtp_pkg::ST_EXP_OVF;
                end
            end
        end else if (r_state == dtp_pkg::S_IDLE && w_accept) begin
            // End marker: set up the result fields.
            n_word = r_word;
            n_seen = r_seen;
            n_idx  = '0;
            if (r_ps == dtp_pkg::PS_END_INF) begin
                n_kind    = dtp_pkg::KIND_INF;
                n_exp_out = dtp_pkg::EXP_MAX;
                n_held    = '0;
            end else if (r_ps == dtp_pkg::PS_END_NAN) begin
                n_kind    = dtp_pkg::KIND_NAN;
                n_exp_out = 16'sd0;
                n_held    = '0;
            end else if (r_ps inside {dtp_pkg::PS_START, dtp_pkg::PS_SIGNED,
                                      dtp_pkg::PS_EXP0, dtp_pkg::PS_EXP1,
                                      dtp_pkg::PS_WORD, dtp_pkg::PS_ERR}) begin
                n_kind    = dtp_pkg::KIND_NUMBER;
                n_exp_out = 16'sd0;
                n_held    = '0;
                n_sign    = 1'b0;
                n_ec      = dtp_pkg::ST_SYNTAX;
            end else begin
                n_kind = dtp_pkg::KIND_NUMBER;
                // A bare zero integer part keeps one zero digit.
                if (r_ps == dtp_pkg::PS_INT && r_held == '0) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wdata = 4'd0;
                    n_held  = CW'(1);
                end
            end
        end else if (r_state == dtp_pkg::S_EXPSUM) begin
            // Signed exponent literal plus the digit offset, saturated.
            n_word    = r_word;
            n_seen    = r_seen;
            n_exp_out = w_add.sum;
            if (w_add.ovf && r_ec == dtp_pkg::ST_OK) begin
                n_ec = dtp_pkg::ST_EXP_OVF;
            end
        end else if (r_state == dtp_pkg::S_SCAN_CHK) begin
            // Strip one trailing zero per check.
            n_word = r_word;
            n_seen = r_seen;
            if (w_rdata == 4'd0) begin
                n_held = w_len_m1;
            end
        end else if (r_state == dtp_pkg::S_EMIT_OUT && i_out_ready) begin
            if (w_last) begin
                // Number done: the parser starts over.
                n_ps     = dtp_pkg::PS_START;
                n_held   = '0;
                n_acc    = '0;
                n_offset = 16'sd0;
                n_expneg = 1'b0;
                n_sign   = 1'b0;
                n_word   = '0;
                n_seen   = '0;
                n_ec     = dtp_pkg::ST_OK;
                n_idx    = '0;
            end else begin
                n_word = r_word;
                n_seen = r_seen;
                n_idx  = r_idx + CW'(1);
            end
        end else begin
            n_word = r_word;
            n_seen = r_seen;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dtp_pkg::S_IDLE;
            r_ps      <= dtp_pkg::PS_START;
            r_held    <= '0;
            r_acc     <= '0;
            r_offset  <= 16'sd0;
            r_expneg  <= 1'b0;
            r_sign    <= 1'b0;
            r_word    <= '0;
            r_seen    <= '0;
            r_ec      <= dtp_pkg::ST_OK;
            r_idx     <= '0;
            r_kind    <= dtp_pkg::KIND_NUMBER;
            r_exp_out <= 16'sd0;
        end else begin
            r_state   <= n_state;
            r_ps      <= n_ps;
            r_held    <= n_held;
            r_acc     <= n_acc;
            r_offset  <= n_offset;
            r_expneg  <= n_expneg;
            r_sign    <= n_sign;
            r_word    <= n_word;
            r_seen    <= n_seen;
            r_ec      <= n_ec;
            r_idx     <= n_idx;
            r_kind    <= n_kind;
            r_exp_out <= n_exp_out;
        end
    end

    // Result beat fields, all held in registers during the beat.
    assign o_digit        = (r_held == '0) ? 4'd0 : w_rdata;
    assign o_last         = w_last;
    assign o_negative     = r_sign;
    assign o_exponent     = r_exp_out;
    assign o_digit_count  = 6'(r_held);
    assign o_special_kind = r_kind;
    assign o_status       = r_ec;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import dtp_pkg::*;

    localparam int         DIGIT_CAP     = 32;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         LINGER_CYCLES = 200;
    localparam int         IDLE_PCT      = 37;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    // One result beat, laid out so that a whole beat compares in one go.
    typedef struct packed {
        logic [3:0]         digit;
        logic               last;
        logic               negative;
        logic signed [15:0] exponent;
        logic [5:0]         count;
        logic [1:0]         kind;
        logic [1:0]         status;
    } digit_beat_t;

    // Character classes of the number syntax.
    function automatic bit blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit letter_char(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic bit numeral_char(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        return (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
    endfunction

    // Tracks the parse of the text sent so far and holds the digit beats
    // that the end marker of each number must produce.
    class parse_tracker;
        t_parse_state pstate;
        logic [3:0]   mantissa [DIGIT_CAP];
        int           held;
        int           exp_acc;
        int           exp_shift;
        bit           exp_minus;
        bit           minus;
        logic [7:0]   word_buf [4];
        int           seen;
        logic [1:0]   flags;
        digit_beat_t  expected_beats [$];
        int           faults;
        int           beats_checked;
        int           beats_predicted;
        int           n_numbers;
        int           n_specials;
        int           n_syntax;
        int           n_flagged;

        function new();
            restart();
        endfunction

        function void restart();
            pstate    = PS_START;
            held      = 0;
            exp_acc   = 0;
            exp_shift = 0;
            exp_minus = 1'b0;
            minus     = 1'b0;
            foreach (word_buf[i]) word_buf[i] = 8'd0;
            seen      = 0;
            flags     = ST_OK;
        endfunction

        // Overflow and digit-limit flags only stick if nothing came first.
        function void raise(input logic [1:0] code);
            if (flags == ST_OK) flags = code;
        endfunction

        function void syntax_fault();
            flags  = ST_SYNTAX;
            pstate = PS_ERR;
        endfunction

        // Digits past the buffer are dropped but still flagged.
        function void push_digit(input int d);
            if (held < DIGIT_CAP) begin
                mantissa[held] = d[3:0];
                held++;
            end else begin
                raise(ST_DIGITS);
            end
        endfunction

        // Integer digits also move the decimal point.
        function void int_digit(input int d);
            push_digit(d);
            if (exp_shift < 32767) exp_shift++;
            else raise(ST_EXP_OVF);
        endfunction

        function bit word_hit(input string w);
            int i;
            for (i = 0; i < w.len(); i++) begin
                if (fold_upper(word_buf[i]) != 8'(w[i])) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void frac_step(input logic [7:0] c);
            if (numeral_char(c)) push_digit(c - CH_ZERO);
            else if (c == CH_E_LC || c == CH_E_UC) pstate = PS_EXP0;
            else if (blank_char(c)) pstate = PS_END;
            else syntax_fault();
        endfunction

        // Exponent literal saturates at the 16-bit maximum.
        function void exp_step(input logic [7:0] c);
            int d;
            if (numeral_char(c)) begin
                d = c - CH_ZERO;
                if (exp_acc > (32767 - d) / 10) begin
                    raise(ST_EXP_OVF);
                    exp_acc = 32767;
                end else begin
                    exp_acc = exp_acc * 10 + d;
                end
                pstate = PS_EXP;
            end else if (blank_char(c)) begin
                pstate = PS_END;
            end else begin
                syntax_fault();
            end
        endfunction

        // Words are matched on the raw character count, leading blanks included.
        function void word_step(input logic [7:0] c);
            if (seen > 4) begin
                syntax_fault();
                return;
            end
            if (!letter_char(c) || seen < 3) return;
            if ((seen == 3 && word_hit("INF")) || (seen == 4 && word_hit("+INF"))) begin
                pstate = PS_END_INF;
            end else if (seen == 4 && word_hit("-INF")) begin
                minus  = 1'b1;
                pstate = PS_END_INF;
            end else if (seen == 3 && word_hit("NAN")) begin
                pstate = PS_END_NAN;
            end
        endfunction

        function void take_char(input logic [7:0] c);
            if (seen < 4) word_buf[seen] = c;
            if (seen < 7) seen++;
            case (pstate)
                PS_START, PS_SIGNED: begin
                    if (pstate == PS_START && c == CH_PLUS) begin
                        pstate = PS_SIGNED;
                    end else if (pstate == PS_START && c == CH_MINUS) begin
                        minus  = 1'b1;
                        pstate = PS_SIGNED;
                    end else if (c == CH_DOT) begin
                        pstate = PS_DOT0;
                    end else if (c == CH_ZERO) begin
                        pstate = PS_INT;
                    end else if (numeral_char(c)) begin
                        int_digit(c - CH_ZERO);
                        pstate = PS_INT;
                    end else if (letter_char(c)) begin
                        pstate = PS_WORD;
                    end else if (!(pstate == PS_START && blank_char(c))) begin
                        syntax_fault();
                    end
                end
                PS_INT: begin
                    // Leading zeros are skipped.
                    if (c == CH_ZERO && held == 0) begin
                    end else if (numeral_char(c)) begin
                        int_digit(c - CH_ZERO);
                    end else if (c == CH_DOT) begin
                        pstate = (held == 0) ? PS_DOT0 : PS_FRAC;
                    end else if (c == CH_E_LC || c == CH_E_UC) begin
                        pstate = PS_EXP0;
                    end else if (blank_char(c)) begin
                        pstate = PS_END;
                    end else begin
                        syntax_fault();
                    end
                end
                PS_DOT0: begin
                    // Zeros right after the dot shift the exponent down; a zero
                    // mantissa before e/E collapses to the single digit 0.
                    if (c == CH_ZERO) begin
                        if (exp_shift > -32768) exp_shift--;
                        else raise(ST_EXP_OVF);
                    end else if (c == CH_E_LC || c == CH_E_UC) begin
                        if (exp_shift == 0) begin
                            syntax_fault();
                        end else begin
                            held = 0;
                            push_digit(0);
                            exp_shift = 0;
                            pstate    = PS_EXP0;
                        end
                    end else begin
                        pstate = PS_FRAC;
                        frac_step(c);
                    end
                end
                PS_FRAC: frac_step(c);
                PS_EXP0: begin
                    if (c == CH_PLUS) begin
                        pstate = PS_EXP1;
                    end else if (c == CH_MINUS) begin
                        exp_minus = 1'b1;
                    end else begin
                        pstate = PS_EXP1;
                        exp_step(c);
                    end
                end
                PS_EXP1, PS_EXP: exp_step(c);
                PS_WORD: word_step(c);
                PS_END, PS_END_INF, PS_END_NAN: begin
                    if (!blank_char(c)) syntax_fault();
                end
                default: ;
            endcase
        endfunction

        // Called for every accepted input beat.
        function void accept_char(input logic [7:0] c, input logic fin);
            int          e;
            int          count;
            int          n;
            int          i;
            logic [1:0]  kind;
            digit_beat_t b;
            if (!fin) begin
                take_char(c);
                return;
            end
            b     = '0;
            kind  = KIND_NUMBER;
            e     = 0;
            count = 0;
            case (pstate)
                PS_START, PS_SIGNED, PS_EXP0, PS_EXP1, PS_WORD, PS_ERR: begin
                    // Incomplete or bad text: a single bare syntax-error beat.
                    b.last   = 1'b1;
                    b.status = ST_SYNTAX;
                    expected_beats.push_back(b);
                    beats_predicted++;
                    n_syntax++;
                    restart();
                    return;
                end
                PS_END_INF: begin
                    kind = KIND_INF;
                    e    = 32767;
                end
                PS_END_NAN: kind = KIND_NAN;
                default: begin
                    if (pstate == PS_INT && held == 0) push_digit(0);
                    e = exp_minus ? -exp_acc : exp_acc;
                    e += exp_shift;
                    if (e > 32767) begin
                        e = 32767;
                        raise(ST_EXP_OVF);
                    end
                    if (e < -32768) begin
                        e = -32768;
                        raise(ST_EXP_OVF);
                    end
                    // Strip trailing zeros but keep at least one digit.
                    count = held;
                    while (count > 1 && mantissa[count - 1] == 4'd0) count--;
                end
            endcase
            n = (count == 0) ? 1 : count;
            for (i = 0; i < n; i++) begin
                b.digit    = (i < count) ? mantissa[i] : 4'd0;
                b.last     = (i == n - 1);
                b.negative = minus;
                b.exponent = e[15:0];
                b.count    = count[5:0];
                b.kind     = kind;
                b.status   = flags;
                expected_beats.push_back(b);
                beats_predicted++;
            end
            if (kind == KIND_NUMBER) n_numbers++;
            else n_specials++;
            if (flags != ST_OK) n_flagged++;
            restart();
        endfunction

        function void check_digit_beat(input digit_beat_t got);
            digit_beat_t want;
            if (expected_beats.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("ERROR: unexpected beat digit=%0d last=%0b exp=%0d status=%0d",
                             got.digit, got.last, got.exponent, got.status);
                return;
            end
            want = expected_beats.pop_front();
            beats_checked++;
            if (got !== want) begin
                faults++;
                if (faults <= 10) begin
                    $display("ERROR: beat %0d expected digit=%0d last=%0b neg=%0b exp=%0d cnt=%0d kind=%0d status=%0d",
                             beats_checked, want.digit, want.last, want.negative,
                             want.exponent, want.count, want.kind, want.status);
                    $display("       got      digit=%0d last=%0b neg=%0b exp=%0d cnt=%0d kind=%0d status=%0d",
                             got.digit, got.last, got.negative, got.exponent,
                             got.count, got.kind, got.status);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [7:0]         in_char   = 8'd0;
    logic               in_finish = 1'b0;
    logic               out_ready = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic [3:0]         out_digit;
    logic               out_last;
    logic               out_negative;
    logic signed [15:0] out_exponent;
    logic [5:0]         out_count;
    logic [1:0]         out_kind;
    logic [1:0]         out_status;

    parse_tracker sb;
    bit           steady   = 1'b0;
    bit           hold_req = 1'b0;
    int           beats_sent;
    int           ends_sent;
    logic [7:0]   text [$];

    decimal_text_parser #(
        .MAX_DIGITS(DIGIT_CAP)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_character   (in_char),
        .i_finish      (in_finish),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_digit       (out_digit),
        .o_last        (out_last),
        .o_negative    (out_negative),
        .o_exponent    (out_exponent),
        .o_digit_count (out_count),
        .o_special_kind(out_kind),
        .o_status      (out_status)
    );

    // Clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: check accepted beats, stall at random, and hold off once
    // for a long stretch when asked.
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && out_ready && out_valid)
                sb.check_digit_beat({out_digit, out_last, out_negative, out_exponent,
                                     out_count, out_kind, out_status});
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Offer one input beat, idling first at random, and wait for acceptance.
    task automatic push_beat(input logic [7:0] c, input logic fin);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_char   <= c;
        in_finish <= fin;
        do @(posedge clk); while (!in_ready);
        sb.accept_char(c, fin);
        beats_sent++;
        if (fin) ends_sent++;
    endtask

    // The character on an end-marker beat is ignored, so it is random.
    task automatic send_end();
        push_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic run_case(input string s);
        int i;
        for (i = 0; i < s.len(); i++) push_beat(8'(s[i]), 1'b0);
        send_end();
    endtask

    task automatic add_digits(input int n, input int zero_pct);
        repeat (n) begin
            if ($urandom_range(0, 99) < zero_pct) text.push_back(CH_ZERO);
            else text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic add_blanks(input int n);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) text.push_back(8'($urandom_range(9, 13)));
            else text.push_back(CH_SPACE);
        end
    endtask

    task automatic add_sign();
        case ($urandom_range(0, 2))
            1: text.push_back(CH_PLUS);
            2: text.push_back(CH_MINUS);
            default: ;
        endcase
    endtask

    // A syntactically sound number with random content.
    task automatic build_wellformed();
        int n_int;
        int n_frac;
        bit has_dot;
        add_blanks(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
        add_sign();
        n_int   = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
        has_dot = $urandom_range(0, 1);
        n_frac  = has_dot ? $urandom_range(0, 5) : 0;
        if (n_int == 0 && n_frac == 0) n_int = 1;
        add_digits(n_int, 30);
        if (has_dot) begin
            text.push_back(CH_DOT);
            add_digits(n_frac, 40);
        end
        if ($urandom_range(0, 99) < 40) begin
            text.push_back($urandom_range(0, 1) ? CH_E_UC : CH_E_LC);
            add_sign();
            add_digits($urandom_range(1, 5), 20);
        end
        add_blanks(($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0);
    endtask

    // One of the special words in mixed case, sometimes with junk after it.
    task automatic build_word();
        string      w;
        logic [7:0] c;
        int         i;
        case ($urandom_range(0, 3))
            0: w = "inf";
            1: w = "+inf";
            2: w = "-inf";
            default: w = "nan";
        endcase
        for (i = 0; i < w.len(); i++) begin
            c = 8'(w[i]);
            if (letter_char(c) && $urandom_range(0, 1)) c = c - 8'd32;
            text.push_back(c);
        end
        add_blanks($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) text.push_back(8'($urandom_range(97, 122)));
    endtask

    initial begin
        int         i;
        int         pick;
        int         number_no;
        int         start_beats;
        int         start_results;
        sb = new();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain numbers, every blank byte, words, and the corner cases.
        run_case("0");
        run_case("-12.3400e+5");
        run_case("+0.00123E-7");
        for (i = 9; i <= 13; i++) push_beat(8'(i), 1'b0);
        push_beat(CH_SPACE, 1'b0);
        run_case("42 ");
        run_case(".");
        run_case("0.00");
        run_case("0.0e5");
        run_case(".e5");
        run_case("");
        run_case("-");
        run_case("1e-");
        run_case("1E+");
        run_case("1.e5");
        run_case("inf");
        run_case("+INF");
        run_case("-Inf");
        run_case("NaN  ");
        run_case("infinity");
        run_case(" inf");
        run_case("abcde");
        run_case("1e99999");
        run_case("9e32767");
        run_case("0.005e-32767");
        run_case("0.05e-32767");
        run_case("123456789012345678901234567890123450");
        run_case("1000000000000000000000000000000000000000");
        run_case("12 3");
        run_case("00012.500");
        run_case("1e1x");
        run_case("+.5");
        run_case("--1");
        push_beat(CH_ZERO + 8'd7, 1'b0);
        push_beat(8'hFF, 1'b0);
        send_end();
        push_beat(8'h00, 1'b0);
        send_end();

        // Random: mostly sound numbers, then words, noise and broken numbers.
        // The first long number goes out while the result side holds off,
        // so the block backs up and stalls its input.
        start_beats   = beats_sent;
        start_results = sb.beats_predicted;
        number_no     = 0;
        hold_req      = 1'b1;
        while (beats_sent - start_beats < 110 || sb.beats_predicted - start_results < 60) begin
            steady = (number_no >= 6 && number_no < 12);
            text.delete();
            pick = $urandom_range(0, 99);
            if (number_no == 0) begin
                add_digits(20, 10);
            end else if (pick < 60) begin
                build_wellformed();
            end else if (pick < 72) begin
                build_word();
            end else if (pick < 87) begin
                repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
            end else begin
                build_wellformed();
                if ($urandom_range(0, 1))
                    text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
                else
                    void'(text.pop_back());
            end
            foreach (text[k]) push_beat(text[k], 1'b0);
            send_end();
            number_no++;
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // Drain, then watch a while for stray beats.
        while (sb.expected_beats.size() != 0) @(posedge clk);
        repeat (LINGER_CYCLES) @(posedge clk);

        $display("Sent %0d input beats (%0d end markers); checked %0d digit beats, %0d mismatches.",
                 beats_sent, ends_sent, sb.beats_checked, sb.faults);
        $display("Parsed %0d numbers, %0d inf/nan words, %0d syntax errors, %0d overflow or digit-limit flags.",
                 sb.n_numbers, sb.n_specials, sb.n_syntax, sb.n_flagged);
        if (sb.faults == 0 && sb.expected_beats.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
